// ===== src/cbc_pkg.sv =====
// shared types, constants and helper functions of the balance current controller
`timescale 1ns / 1ps
package cbc_pkg;

    // fixed-point constants (q16.16) and the first tick's elapsed time in ms
    localparam logic signed [63:0] AngleOffset  = 64'sd1837;
    localparam logic signed [63:0] AngleLimit   = 64'sd16013;
    localparam logic signed [63:0] IntegLimit   = 64'sd13107;
    localparam logic [31:0]        FirstDtMs    = 32'd10;

    // deadzone offsets per side
    localparam logic signed [31:0] DzLeftPos    = 32'sd0;
    localparam logic signed [31:0] DzLeftNeg    = 32'sd0;
    localparam logic signed [31:0] DzRightPos   = 32'sd0;
    localparam logic signed [31:0] DzRightNeg   = 32'sd0;

    // divide by 1000: clip bound and reciprocal floor(2^35 / 1000)
    localparam logic [65:0] DivClip     = 66'd32768000;
    localparam logic [24:0] DivClipMax  = 25'd32767999;
    localparam logic [25:0] DivRecip    = 26'd34359738;
    localparam int          DivShift    = 35;

    // register map
    localparam int          RegAddrW    = 5;
    typedef enum logic [2:0] {
        REG_OUTER_PROP  = 3'd0,
        REG_OUTER_ACCEL = 3'd1,
        REG_OUTER_INTEG = 3'd2,
        REG_ANGLE       = 3'd3,
        REG_RATE        = 3'd4,
        REG_ANGLE_INTEG = 3'd5,
        REG_F2C         = 3'd6,
        REG_UNUSED      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [31:0] time_ms;
        logic signed [31:0] target_vel_left;
        logic signed [31:0] target_vel_right;
        logic signed [31:0] body_angle;
        logic signed [31:0] body_rate;
        logic signed [31:0] wheel_vel_left;
        logic signed [31:0] wheel_acc_left;
        logic signed [31:0] wheel_vel_right;
        logic signed [31:0] wheel_acc_right;
        logic signed [31:0] leg_offset_left;
        logic signed [31:0] leg_offset_right;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] right_motor_current;
        logic signed [31:0] left_motor_current;
        logic signed [31:0] mean_force;
        logic signed [31:0] desired_angle_left;
        logic signed [31:0] desired_angle_right;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] outer_prop_gain;
        logic signed [31:0] outer_accel_gain;
        logic signed [31:0] outer_integral_gain;
        logic signed [31:0] angle_gain;
        logic signed [31:0] rate_gain;
        logic signed [31:0] angle_integral_gain;
        logic signed [31:0] force_to_current;
    } t_gains;

    // per-side inputs of one lane
    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] leg;
    } t_side_in;

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    typedef struct packed {
        logic               done;
        logic signed [63:0] cur;
        logic signed [31:0] force_val;
        logic signed [31:0] des_tel;
    } t_lane_sts;

    typedef enum logic [4:0] {
        L_IDLE, L_VMUL, L_VDIV, L_VFIX, L_OP, L_OA, L_OI, L_DES,
        L_AMUL, L_ADIV, L_AFIX, L_IA, L_IR, L_II, L_FRC, L_CUR, L_FIN, L_DONE
    } t_lane_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // q16.16 product scaling, floor
    function automatic logic signed [63:0] qsh(input logic signed [65:0] p);
        return {{14{p[65]}}, p[65:16]};
    endfunction

endpackage

// ===== src/cbc_if.sv =====
// valid/ready channel interfaces for input ticks and result beats
`timescale 1ns / 1ps
interface cbc_in_if;
    logic               valid;
    logic               ready;
    cbc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbc_out_if;
    logic               valid;
    logic               ready;
    cbc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cbc_lane.sv =====
// one side of the controller: outer pid and inner lqi on a shared multiplier
`timescale 1ns / 1ps
module cbc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbc_pkg::t_gains    i_gains,
    input  cbc_pkg::t_side_in  i_side,
    input  logic signed [31:0] i_angle,
    input  logic signed [31:0] i_rate,
    input  logic        [31:0] i_dt,
    input  logic signed [31:0] i_dz_pos,
    input  logic signed [31:0] i_dz_neg,
    input  cbc_pkg::t_lane_ctl i_ctl,
    output cbc_pkg::t_lane_sts o_sts
);
    cbc_pkg::t_lane_state r_state, n_state;

    logic signed [31:0] r_verr, r_aerr, r_force, r_des_tel;
    logic signed [31:0] r_vint, r_aint;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc, r_cur;
    logic        [24:0] r_x;
    logic               r_neg;
    logic        [50:0] r_qp;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mul;
    logic signed [63:0] w_sum, w_des, w_desc, w_prodq;
    logic        [65:0] w_mag;
    logic        [24:0] w_x;
    logic        [15:0] w_q0;
    logic        [26:0] w_rem;
    logic        [15:0] w_q;
    logic signed [63:0] w_inc, w_integ, w_base;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbc_pkg::L_IDLE: if (i_ctl.start) n_state = cbc_pkg::L_VMUL;
            cbc_pkg::L_VMUL: n_state = cbc_pkg::L_VDIV;
            cbc_pkg::L_VDIV: n_state = cbc_pkg::L_VFIX;
            cbc_pkg::L_VFIX: n_state = cbc_pkg::L_OP;
            cbc_pkg::L_OP:   n_state = cbc_pkg::L_OA;
            cbc_pkg::L_OA:   n_state = cbc_pkg::L_OI;
            cbc_pkg::L_OI:   n_state = cbc_pkg::L_DES;
            cbc_pkg::L_DES:  n_state = cbc_pkg::L_AMUL;
            cbc_pkg::L_AMUL: n_state = cbc_pkg::L_ADIV;
            cbc_pkg::L_ADIV: n_state = cbc_pkg::L_AFIX;
            cbc_pkg::L_AFIX: n_state = cbc_pkg::L_IA;
            cbc_pkg::L_IA:   n_state = cbc_pkg::L_IR;
            cbc_pkg::L_IR:   n_state = cbc_pkg::L_II;
            cbc_pkg::L_II:   n_state = cbc_pkg::L_FRC;
            cbc_pkg::L_FRC:  n_state = cbc_pkg::L_CUR;
            cbc_pkg::L_CUR:  n_state = cbc_pkg::L_FIN;
            cbc_pkg::L_FIN:  n_state = cbc_pkg::L_DONE;
            cbc_pkg::L_DONE: if (i_ctl.take) n_state = cbc_pkg::L_IDLE;
            default:         n_state = cbc_pkg::L_IDLE;
        endcase
    end

    // multiplier operand select per state
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            cbc_pkg::L_VMUL: begin w_ma = 33'(r_verr); w_mb = {1'b0, i_dt}; end
            cbc_pkg::L_OP: begin
                w_ma = 33'(i_gains.outer_prop_gain); w_mb = 33'(r_verr);
            end
            cbc_pkg::L_OA: begin
                w_ma = 33'(i_gains.outer_accel_gain); w_mb = 33'(i_side.acc);
            end
            cbc_pkg::L_OI: begin
                w_ma = 33'(i_gains.outer_integral_gain); w_mb = 33'(r_vint);
            end
            cbc_pkg::L_AMUL: begin w_ma = 33'(r_aerr); w_mb = {1'b0, i_dt}; end
            cbc_pkg::L_IA: begin w_ma = 33'(i_gains.angle_gain); w_mb = 33'(r_aerr); end
            cbc_pkg::L_IR: begin w_ma = 33'(i_gains.rate_gain); w_mb = 33'(i_rate); end
            cbc_pkg::L_II: begin
                w_ma = 33'(i_gains.angle_integral_gain); w_mb = 33'(r_aint);
            end
            cbc_pkg::L_CUR: begin
                w_ma = 33'(r_force); w_mb = 33'(i_gains.force_to_current);
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_mul   = w_ma * w_mb;
    assign w_prodq = cbc_pkg::qsh(r_prod);
    assign w_sum   = r_acc + w_prodq;

    // desired angle and its clamp
    assign w_des  = -w_sum;
    assign w_desc = cbc_pkg::clampv(w_des, cbc_pkg::AngleLimit);

    // error * dt / 1000 toward zero; magnitude clipped where the integral clamp rules anyway
    assign w_mag   = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
    assign w_x     = (w_mag >= cbc_pkg::DivClip) ? cbc_pkg::DivClipMax : w_mag[24:0];
    assign w_q0    = r_qp[50:cbc_pkg::DivShift];
    assign w_rem   = {2'b00, r_x} - (27'(w_q0) * 27'd1000);
    assign w_q     = (w_rem >= 27'd1000) ? w_q0 + 16'd1 : w_q0;
    assign w_inc   = r_neg ? -64'(w_q) : 64'(w_q);
    assign w_base  = (r_state == cbc_pkg::L_VFIX) ? 64'(r_vint) : 64'(r_aint);
    assign w_integ = cbc_pkg::clampv(w_base + w_inc, cbc_pkg::IntegLimit);

    // state and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbc_pkg::L_IDLE;
            r_vint  <= '0;
            r_aint  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == cbc_pkg::L_VFIX && i_gains.outer_integral_gain > 32'sd0) begin
                r_vint <= w_integ[31:0];
            end
            if (r_state == cbc_pkg::L_AFIX) begin
                r_aint <= w_integ[31:0];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cbc_pkg::L_IDLE: begin
                r_verr <= cbc_pkg::sat32(64'(i_side.vel) - 64'(i_side.target));
            end
            cbc_pkg::L_VMUL, cbc_pkg::L_OP, cbc_pkg::L_AMUL, cbc_pkg::L_IA,
            cbc_pkg::L_CUR: begin
                r_prod <= w_mul;
            end
            cbc_pkg::L_VDIV, cbc_pkg::L_ADIV: begin
                r_x   <= w_x;
                r_neg <= r_prod[65];
                r_qp  <= 51'(w_x) * 51'(cbc_pkg::DivRecip);
            end
            cbc_pkg::L_OA, cbc_pkg::L_IR: begin
                r_acc  <= w_prodq;
                r_prod <= w_mul;
            end
            cbc_pkg::L_OI, cbc_pkg::L_II: begin
                r_acc  <= w_sum;
                r_prod <= w_mul;
            end
            cbc_pkg::L_DES: begin
                r_des_tel <= cbc_pkg::sat32(w_des);
                r_aerr    <= cbc_pkg::sat32(64'(i_angle) - cbc_pkg::AngleOffset
                                            + 64'(i_side.leg) - w_desc);
            end
            cbc_pkg::L_FRC: begin
                r_force <= cbc_pkg::sat32(-w_sum);
            end
            cbc_pkg::L_FIN: begin
                if (w_prodq > 64'sd0) begin
                    r_cur <= w_prodq + 64'(i_dz_pos);
                end else if (w_prodq < 64'sd0) begin
                    r_cur <= w_prodq - 64'(i_dz_neg);
                end else begin
                    r_cur <= w_prodq;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done      = (r_state == cbc_pkg::L_DONE);
    assign o_sts.cur       = r_cur;
    assign o_sts.force_val = r_force;
    assign o_sts.des_tel   = r_des_tel;

endmodule

// ===== src/cbc_merge.sv =====
// combines both lanes into one result beat held in the output register
`timescale 1ns / 1ps
module cbc_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbc_pkg::t_lane_sts i_left,
    input  cbc_pkg::t_lane_sts i_right,
    output logic               o_take,
    cbc_out_if.source          o_out
);
    logic               r_valid;
    cbc_pkg::t_out_item r_data, w_data;
    logic signed [32:0] w_fsum;

    // move when both lanes are done and the output slot is free
    assign o_take = i_left.done && i_right.done && (!r_valid || o_out.ready);

    // mean of the forces, floor
    assign w_fsum = 33'(i_left.force_val) + 33'(i_right.force_val);

    always_comb begin
        w_data.right_motor_current = cbc_pkg::sat32(-i_right.cur);
        w_data.left_motor_current  = cbc_pkg::sat32(i_left.cur);
        w_data.mean_force          = w_fsum[32:1];
        w_data.desired_angle_left  = i_left.des_tel;
        w_data.desired_angle_right = i_right.des_tel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= w_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

// ===== src/cascaded_balance_current_controller_core.sv =====
// top level of the cascaded balance current controller
//
// Usage: each beat on i_in is one control tick of a two-wheeled balancer; each
// tick yields exactly one result beat on o_out with both motor currents, the
// mean force and the unclamped desired angles. Gains are written over the APB
// port (register i at byte address 4*i); the user must write them only while
// the block is idle, which the block itself does not enforce. Two lanes, left
// and right, run the outer pid and inner lqi side by side, each through its own
// 33x33 multiplier stepped by a small sequencer; a merge stage forms the
// result beat in an output register. One tick is in flight at a time: a new
// tick is taken only once the lane sequencer has run nine multiplies plus two
// divide-by-1000 passes and the merge stage has taken both lanes' results.
// Reset: gains take their defaults, integrators and the last tick stamp clear,
// no result is pending. When the receiver stalls, the result waits in the
// output register; the next tick may be accepted and runs to completion, then
// holds in the lanes until the output register frees.
`timescale 1ns / 1ps
module cascaded_balance_current_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cbc_in_if.sink                        i_in,
    cbc_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbc_pkg::RegAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    cbc_pkg::t_gains    r_gains;
    cbc_pkg::t_in_item  r_item;
    logic        [31:0] r_last, r_dt;
    logic               r_busy;
    logic               w_accept, w_take, w_wr;
    cbc_pkg::t_reg_idx  w_idx;
    cbc_pkg::t_lane_ctl w_ctl;
    cbc_pkg::t_lane_sts w_sts_l, w_sts_r;
    cbc_pkg::t_side_in  w_side_l, w_side_r;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_busy;

    // register file
    assign pready = 1'b1;
    assign w_idx  = cbc_pkg::t_reg_idx'(paddr[cbc_pkg::RegAddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.outer_prop_gain     <= 32'sd8520;
            r_gains.outer_accel_gain    <= -32'sd983;
            r_gains.outer_integral_gain <= 32'sd16384;
            r_gains.angle_gain          <= 32'sd6553600;
            r_gains.rate_gain           <= 32'sd655360;
            r_gains.angle_integral_gain <= -32'sd1179648;
            r_gains.force_to_current    <= 32'sd65536;
        end else if (w_wr) begin
            unique case (w_idx)
                cbc_pkg::REG_OUTER_PROP:  r_gains.outer_prop_gain     <= pwdata;
                cbc_pkg::REG_OUTER_ACCEL: r_gains.outer_accel_gain    <= pwdata;
                cbc_pkg::REG_OUTER_INTEG: r_gains.outer_integral_gain <= pwdata;
                cbc_pkg::REG_ANGLE:       r_gains.angle_gain          <= pwdata;
                cbc_pkg::REG_RATE:        r_gains.rate_gain           <= pwdata;
                cbc_pkg::REG_ANGLE_INTEG: r_gains.angle_integral_gain <= pwdata;
                cbc_pkg::REG_F2C:         r_gains.force_to_current    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            cbc_pkg::REG_OUTER_PROP:  prdata = r_gains.outer_prop_gain;
            cbc_pkg::REG_OUTER_ACCEL: prdata = r_gains.outer_accel_gain;
            cbc_pkg::REG_OUTER_INTEG: prdata = r_gains.outer_integral_gain;
            cbc_pkg::REG_ANGLE:       prdata = r_gains.angle_gain;
            cbc_pkg::REG_RATE:        prdata = r_gains.rate_gain;
            cbc_pkg::REG_ANGLE_INTEG: prdata = r_gains.angle_integral_gain;
            cbc_pkg::REG_F2C:         prdata = r_gains.force_to_current;
            default:                  prdata = '0;
        endcase
    end

    // tick timing and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_busy <= 1'b0;
        end else begin
            if (w_accept) begin
                r_last <= i_in.data.time_ms;
                r_busy <= 1'b1;
            end else if (w_take) begin
                r_busy <= 1'b0;
            end
        end
    end

    // captured tick payload and elapsed time
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
            r_dt   <= (r_last == 32'd0) ? cbc_pkg::FirstDtMs : i_in.data.time_ms - r_last;
        end
    end

    // lane start follows accept in the next cycle, once the payload is captured
    logic r_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept;
        end
    end

    assign w_ctl.start = r_start;
    assign w_ctl.take  = w_take;

    assign w_side_l.target = r_item.target_vel_left;
    assign w_side_l.vel    = r_item.wheel_vel_left;
    assign w_side_l.acc    = r_item.wheel_acc_left;
    assign w_side_l.leg    = r_item.leg_offset_left;
    assign w_side_r.target = r_item.target_vel_right;
    assign w_side_r.vel    = r_item.wheel_vel_right;
    assign w_side_r.acc    = r_item.wheel_acc_right;
    assign w_side_r.leg    = r_item.leg_offset_right;

    cbc_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gains  (r_gains),
        .i_side   (w_side_l),
        .i_angle  (r_item.body_angle),
        .i_rate   (r_item.body_rate),
        .i_dt     (r_dt),
        .i_dz_pos (cbc_pkg::DzLeftPos),
        .i_dz_neg (cbc_pkg::DzLeftNeg),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts_l)
    );

    cbc_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gains  (r_gains),
        .i_side   (w_side_r),
        .i_angle  (r_item.body_angle),
        .i_rate   (r_item.body_rate),
        .i_dt     (r_dt),
        .i_dz_pos (cbc_pkg::DzRightPos),
        .i_dz_neg (cbc_pkg::DzRightNeg),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts_r)
    );

    cbc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_left  (w_sts_l),
        .i_right (w_sts_r),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ===== src/cbc_checker.sv =====
// port-level checks of the controller core and their binding
`timescale 1ns / 1ps
module cbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pready
);
    // one tick at a time: no new beat is taken right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a tick is in flight");

    // a result never appears the cycle after a tick is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result beat too soon after accept");

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped under stall");

    // apb never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");
endmodule

bind cascaded_balance_current_controller_core cbc_checker u_cbc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .pready    (pready)
);

// ===== dv/tb.sv =====
// testbench of the balance current controller: directed and random ticks checked against a predictor
`timescale 1ns / 1ps
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [cbc_pkg::RegAddrW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    cbc_in_if  tick_ch ();
    cbc_out_if res_ch ();

    cascaded_balance_current_controller_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(tick_ch.sink), .o_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    cbc_pkg::t_gains     gains_m;
    logic signed [31:0]  vint_l, vint_r, aint_l, aint_r;
    logic [31:0]         last_ms;
    cbc_pkg::t_out_item  expected_q[$];
    int                  n_errors;
    int                  idle_cycles;
    bit                  rx_hold;
    bit                  stim_done;

    function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] integ(input logic signed [31:0] acc,
                                                 input logic signed [31:0] err,
                                                 input logic [31:0] dt);
        logic signed [63:0] inc;
        inc = (64'(err) * $signed({32'd0, dt})) / 64'sd1000;
        return 32'(cbc_pkg::clampv(64'(acc) + inc, cbc_pkg::IntegLimit));
    endfunction

    // one side of the cascade; returns current before saturation
    function automatic void side_calc(input logic signed [31:0] tgt, vel, acc, leg, ang, rate,
                                      input logic [31:0] dt,
                                      inout logic signed [31:0] vint, aint,
                                      input logic signed [31:0] dzp, dzn,
                                      output logic signed [31:0] des_tel, frc,
                                      output logic signed [63:0] cur);
        logic signed [31:0] verr, aerr;
        logic signed [63:0] des, desc;
        verr = cbc_pkg::sat32(64'(vel) - 64'(tgt));
        if (gains_m.outer_integral_gain > 0) vint = integ(vint, verr, dt);
        des = -(qmul(gains_m.outer_prop_gain, verr) + qmul(gains_m.outer_accel_gain, acc)
                + qmul(gains_m.outer_integral_gain, vint));
        des_tel = cbc_pkg::sat32(des);
        desc = cbc_pkg::clampv(des, cbc_pkg::AngleLimit);
        aerr = cbc_pkg::sat32(64'(ang) - cbc_pkg::AngleOffset + 64'(leg) - desc);
        aint = integ(aint, aerr, dt);
        frc = cbc_pkg::sat32(-(qmul(gains_m.angle_gain, aerr)
                               + qmul(gains_m.rate_gain, rate)
                               + qmul(gains_m.angle_integral_gain, aint)));
        cur = qmul(frc, gains_m.force_to_current);
        if (cur > 0) cur = cur + dzp;
        else if (cur < 0) cur = cur - dzn;
    endfunction

    function automatic cbc_pkg::t_out_item predict_currents(input cbc_pkg::t_in_item t);
        cbc_pkg::t_out_item r;
        logic [31:0] dt;
        logic signed [31:0] fl, fr, dl, dr;
        logic signed [63:0] cl, cr, s;
        dt = (last_ms == 0) ? cbc_pkg::FirstDtMs : t.time_ms - last_ms;
        last_ms = t.time_ms;
        side_calc(t.target_vel_left, t.wheel_vel_left, t.wheel_acc_left, t.leg_offset_left,
                  t.body_angle, t.body_rate, dt, vint_l, aint_l,
                  cbc_pkg::DzLeftPos, cbc_pkg::DzLeftNeg, dl, fl, cl);
        side_calc(t.target_vel_right, t.wheel_vel_right, t.wheel_acc_right,
                  t.leg_offset_right, t.body_angle, t.body_rate, dt, vint_r, aint_r,
                  cbc_pkg::DzRightPos, cbc_pkg::DzRightNeg, dr, fr, cr);
        s = 64'(fl) + 64'(fr);
        r.right_motor_current = cbc_pkg::sat32(-cr);
        r.left_motor_current  = cbc_pkg::sat32(cl);
        r.mean_force          = cbc_pkg::sat32(s >>> 1);
        r.desired_angle_left  = dl;
        r.desired_angle_right = dr;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
        n_errors++;
    endtask

    // result checking, receiver stalls
    initial begin
        int wait_n;
        cbc_pkg::t_out_item e;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_n != 0 || rx_hold) begin
                res_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk iff res_ch.valid);
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", res_ch.data.mean_force, '0);
            end else begin
                e = expected_q.pop_front();
                if (res_ch.data.right_motor_current !== e.right_motor_current)
                    report_mismatch("right_motor_current", res_ch.data.right_motor_current,
                                    e.right_motor_current);
                if (res_ch.data.left_motor_current !== e.left_motor_current)
                    report_mismatch("left_motor_current", res_ch.data.left_motor_current,
                                    e.left_motor_current);
                if (res_ch.data.mean_force !== e.mean_force)
                    report_mismatch("mean_force", res_ch.data.mean_force, e.mean_force);
                if (res_ch.data.desired_angle_left !== e.desired_angle_left)
                    report_mismatch("desired_angle_left", res_ch.data.desired_angle_left,
                                    e.desired_angle_left);
                if (res_ch.data.desired_angle_right !== e.desired_angle_right)
                    report_mismatch("desired_angle_right", res_ch.data.desired_angle_right,
                                    e.desired_angle_right);
            end
        end
    end

    // watchdog on cycles without any beat or apb access
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("FAIL cascaded_balance_current_controller_core");
            $finish;
        end
    end

    // apb write, then read back of the register once the bus is idle again
    task automatic write_reg(input cbc_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= cbc_pkg::RegAddrW'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        if (prdata !== val) report_mismatch("prdata", prdata, val);
        case (idx)
            cbc_pkg::REG_OUTER_PROP:  gains_m.outer_prop_gain     = val;
            cbc_pkg::REG_OUTER_ACCEL: gains_m.outer_accel_gain    = val;
            cbc_pkg::REG_OUTER_INTEG: gains_m.outer_integral_gain = val;
            cbc_pkg::REG_ANGLE:       gains_m.angle_gain          = val;
            cbc_pkg::REG_RATE:        gains_m.rate_gain           = val;
            cbc_pkg::REG_ANGLE_INTEG: gains_m.angle_integral_gain = val;
            cbc_pkg::REG_F2C:         gains_m.force_to_current    = val;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // one tick beat; expected value is predicted, or taken from the row when given
    task automatic send_tick(input cbc_pkg::t_in_item t, input bit use_row,
                             input cbc_pkg::t_out_item row, input bit no_gap);
        cbc_pkg::t_out_item p;
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge i_clk iff tick_ch.ready);
        p = predict_currents(t);
        expected_q.push_back(use_row ? row : p);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic cbc_pkg::t_in_item rnd_tick(input logic [31:0] ms);
        cbc_pkg::t_in_item t;
        t.time_ms = ms;
        t.target_vel_left = rnd_val(); t.target_vel_right = rnd_val();
        t.body_angle = rnd_val(); t.body_rate = rnd_val();
        t.wheel_vel_left = rnd_val(); t.wheel_acc_left = rnd_val();
        t.wheel_vel_right = rnd_val(); t.wheel_acc_right = rnd_val();
        t.leg_offset_left = rnd_val(); t.leg_offset_right = rnd_val();
        return t;
    endfunction

    typedef struct {
        cbc_pkg::t_in_item  tick;
        bit                 use_row;
        cbc_pkg::t_out_item row;
    } t_stim_row;

    // stimulus
    initial begin
        t_stim_row           rows[$];
        t_stim_row           r;
        cbc_pkg::t_in_item   t;
        cbc_pkg::t_out_item  none;
        logic [31:0]         now_ms;
        n_errors = 0; rx_hold = 0; stim_done = 0;
        none = '0;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        tick_ch.valid <= 1'b0; tick_ch.data <= '0;
        gains_m = '{32'sd8520, -32'sd983, 32'sd16384, 32'sd6553600, 32'sd655360,
                    -32'sd1179648, 32'sd65536};
        vint_l = 0; vint_r = 0; aint_l = 0; aint_r = 0; last_ms = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: all-zero tick right after reset
        r.tick = '0; r.tick.time_ms = 0; r.use_row = 1;
        r.row = '0;
        // angle offset alone: error -1837, integral -18, force 1837*100-18*18 floor
        r.row.mean_force = 32'sd183700 - 32'sd324;
        r.row.left_motor_current = 32'sd183376;
        r.row.right_motor_current = -32'sd183376;
        rows.push_back(r);
        // stamp after a zero stamp, then normal, large jump, wrap, large elapsed time
        r.use_row = 0; r.row = none;
        r.tick = '0; r.tick.time_ms = 32'd5; rows.push_back(r);
        r.tick.time_ms = 32'd25; r.tick.body_angle = 32'sh00010000; rows.push_back(r);
        r.tick.time_ms = 32'hfffffff0; rows.push_back(r);
        r.tick.time_ms = 32'h00000008; rows.push_back(r);
        r.tick.time_ms = 32'h80000000; rows.push_back(r);
        // field extremes
        r.tick = '{32'hffffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff};
        rows.push_back(r);
        r.tick = '{32'h00000003, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                   32'sh80000000, 32'sh80000000};
        rows.push_back(r);
        r.tick = '{32'h00000004, 32'sh0, 32'sh0, 32'shffffffff, 32'sh1, 32'sh1000,
                   32'sh0, 32'shfffff000, 32'sh0, 32'sh0, 32'sh0};
        rows.push_back(r);
        r.tick.time_ms = 32'd0; rows.push_back(r);
        r.tick.time_ms = 32'd7; rows.push_back(r);
        foreach (rows[i]) send_tick(rows[i].tick, rows[i].use_row, rows[i].row, 0);
        drain_results();

        // sender pauses until all results are in, then register phases
        now_ms = 32'd100;
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: for (int k = 0; k < 7; k++)
                    write_reg(cbc_pkg::t_reg_idx'(k), 32'h7fffffff);
                1: for (int k = 0; k < 7; k++)
                    write_reg(cbc_pkg::t_reg_idx'(k), 32'h80000000);
                2: for (int k = 0; k < 7; k++)
                    write_reg(cbc_pkg::t_reg_idx'(k), 32'h0);
                3: for (int k = 0; k < 7; k++)
                    write_reg(cbc_pkg::t_reg_idx'(k), $urandom());
                4: begin
                    for (int k = 0; k < 7; k++)
                        write_reg(cbc_pkg::t_reg_idx'(k),
                                  32'($signed($urandom_range(0, 2000000)) - 1000000));
                    write_reg(cbc_pkg::REG_OUTER_INTEG, 32'sd16384);
                end
                default: begin
                    write_reg(cbc_pkg::REG_OUTER_PROP, 32'sd8520);
                    write_reg(cbc_pkg::REG_OUTER_ACCEL, -32'sd983);
                    write_reg(cbc_pkg::REG_OUTER_INTEG, 32'sd16384);
                    write_reg(cbc_pkg::REG_ANGLE, 32'sd6553600);
                    write_reg(cbc_pkg::REG_RATE, 32'sd655360);
                    write_reg(cbc_pkg::REG_ANGLE_INTEG, -32'sd1179648);
                    write_reg(cbc_pkg::REG_F2C, 32'sd65536);
                end
            endcase
            for (int n = 0; n < 70; n++) begin
                // mostly small steps in time, sometimes a jump or a zero stamp
                case ($urandom_range(0, 9))
                    0: now_ms = $urandom();
                    1: now_ms = 32'd0;
                    default: now_ms = now_ms + $urandom_range(1, 20);
                endcase
                t = rnd_tick(now_ms);
                // receiver holds off for a long stretch while ticks keep coming
                if (ph == 2 && n == 10) begin
                    rx_hold = 1;
                    fork
                        begin repeat (200) @(posedge i_clk); rx_hold = 0; end
                    join_none
                    send_tick(t, 0, none, 1);
                end else begin
                    send_tick(t, 0, none, 0);
                end
            end
        end

        // final wait with limit
        fork
            begin
                drain_results();
                stim_done = 1;
            end
            begin
                repeat (20000) @(posedge i_clk);
            end
        join_any
        if (!stim_done) begin
            $display("FAIL cascaded_balance_current_controller_core");
        end else if (n_errors == 0) begin
            $display("PASS cascaded_balance_current_controller_core");
        end else begin
            $display("FAIL cascaded_balance_current_controller_core");
        end
        $finish;
    end
endmodule
